### rtl/nvbs_pkg.sv
// Shared types and constants for the nearest value binary search block.
package nvbs_pkg;

    localparam int IDX_W         = 10;
    localparam int VAL_W         = 32;
    localparam int DEPTH_DEFAULT = 1024;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REVERSED = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHK_HI = 6'b000010,
        ST_CHK_LO = 6'b000100,
        ST_SEARCH = 6'b001000,
        ST_PICK   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

endpackage

### rtl/nearest_value_binary_search_top.sv
// Nearest value binary search: sorted value table with an iterative search sequencer.
//
//  channel | direction | handshake           | words
//  --------+-----------+---------------------+------------------------------------------
//  in      | sink      | in_valid / in_stall | action, entry_index, entry_value,
//          |           |                     | lo_index, hi_index, target_value
//  out     | source    | out_valid/out_stall | nearest_index, status
//
// A write word stores the entry at the accepting edge, and the block is ready
// again at once. A query word holds the block while it checks the high end and
// the low end, then halves the range and picks the nearer end; an end check or
// a reversed range settles it early. Each halving step waits on the single table
// read port, since it needs the value read at the previous midpoint. Reset clears
// the sequencer and the output valid; table contents are undefined until written.
// A stalled result holds the output register, and a finished query waits in its
// last step until that register is free, while write words are still taken once
// the block is idle.
module nearest_value_binary_search_top #(
    parameter int DEPTH = nvbs_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic        [nvbs_pkg::IDX_W-1:0] entry_index,
    input  logic signed [nvbs_pkg::VAL_W-1:0] entry_value,
    input  logic        [nvbs_pkg::IDX_W-1:0] lo_index,
    input  logic        [nvbs_pkg::IDX_W-1:0] hi_index,
    input  logic signed [nvbs_pkg::VAL_W-1:0] target_value,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic        [nvbs_pkg::IDX_W-1:0] nearest_index,
    output logic                              status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = nvbs_pkg::IDX_W;
    localparam int VW = nvbs_pkg::VAL_W;

    // value table
    logic signed [VW-1:0] mem [DEPTH];
    logic signed [VW-1:0] rd_data_reg;
    logic        [AW-1:0] rd_addr;

    // sequencer state
    nvbs_pkg::state_t     state_reg, state_next;
    logic        [IW-1:0] lo_reg, lo_next;
    logic        [IW-1:0] hi_reg, hi_next;
    logic        [IW-1:0] mid_reg, mid_next;
    logic signed [VW-1:0] x_reg, x_next;
    logic signed [VW-1:0] vlo_reg, vlo_next;
    logic signed [VW-1:0] vhi_reg, vhi_next;
    logic        [IW-1:0] res_idx_reg, res_idx_next;
    logic                 res_status_reg, res_status_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic        [IW-1:0] nearest_index_reg, nearest_index_next;
    logic                 status_reg, status_next;

    // handshake and decode
    logic                 in_accept;
    logic                 wr_en;
    logic        [IW-1:0] lo_clamp;
    logic        [IW-1:0] hi_clamp;

    // search datapath
    logic        [IW-1:0] cur_lo;
    logic        [IW-1:0] cur_hi;
    logic          [IW:0] mid_sum;
    logic        [IW-1:0] mid_cur;
    logic                 more_steps;
    logic                 rd_gt_x;
    logic signed   [VW:0] d_hi;
    logic signed   [VW:0] d_lo;
    logic                 out_free;

    assign in_stall  = (state_reg != nvbs_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign wr_en     = in_accept && (action == nvbs_pkg::ACT_WRITE)
                       && (32'(entry_index) < DEPTH);

    // out-of-table query indexes saturate to the last entry
    assign lo_clamp = (32'(lo_index) >= DEPTH) ? IW'(DEPTH - 1) : lo_index;
    assign hi_clamp = (32'(hi_index) >= DEPTH) ? IW'(DEPTH - 1) : hi_index;

    // one halving step: the midpoint read last cycle is in rd_data_reg
    assign rd_gt_x = (rd_data_reg > x_reg);
    assign cur_lo  = (state_reg == nvbs_pkg::ST_SEARCH && !rd_gt_x) ? mid_reg : lo_reg;
    assign cur_hi  = (state_reg == nvbs_pkg::ST_SEARCH &&  rd_gt_x) ? mid_reg : hi_reg;
    assign mid_sum = {1'b0, cur_lo} + {1'b0, cur_hi};
    assign mid_cur = mid_sum[IW:1];
    assign more_steps = ({1'b0, cur_hi} > ({1'b0, cur_lo} + (IW+1)'(1)));

    // exact 33-bit distances for the final choice
    assign d_hi = {vhi_reg[VW-1], vhi_reg} - {x_reg[VW-1], x_reg};
    assign d_lo = {x_reg[VW-1], x_reg} - {vlo_reg[VW-1], vlo_reg};

    assign out_free = !out_valid_reg || !out_stall;

    // read address: high end on accept, low end next, then midpoints
    always_comb
    begin
        case (state_reg)
            nvbs_pkg::ST_IDLE:   rd_addr = AW'(hi_clamp);
            nvbs_pkg::ST_CHK_HI: rd_addr = AW'(lo_reg);
            default:             rd_addr = AW'(mid_cur);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(entry_index)] <= entry_value;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next         = state_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        mid_next           = mid_reg;
        x_next             = x_reg;
        vlo_next           = vlo_reg;
        vhi_next           = vhi_reg;
        res_idx_next       = res_idx_reg;
        res_status_next    = res_status_reg;
        out_valid_next     = out_valid_reg && out_stall;
        nearest_index_next = nearest_index_reg;
        status_next        = status_reg;

        case (state_reg)
            nvbs_pkg::ST_IDLE:
            begin
                if (in_accept && action == nvbs_pkg::ACT_QUERY)
                begin
                    lo_next         = lo_clamp;
                    hi_next         = hi_clamp;
                    x_next          = target_value;
                    res_idx_next    = lo_clamp;
                    res_status_next = nvbs_pkg::STATUS_OK;
                    if (hi_clamp < lo_clamp)
                    begin
                        res_status_next = nvbs_pkg::STATUS_REVERSED;
                        state_next      = nvbs_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = nvbs_pkg::ST_CHK_HI;
                    end
                end
            end
            nvbs_pkg::ST_CHK_HI:
            begin
                if (x_reg >= rd_data_reg)
                begin
                    res_idx_next = hi_reg;
                    state_next   = nvbs_pkg::ST_FINISH;
                end
                else
                begin
                    vhi_next   = rd_data_reg;
                    state_next = nvbs_pkg::ST_CHK_LO;
                end
            end
            nvbs_pkg::ST_CHK_LO:
            begin
                if (x_reg <= rd_data_reg)
                begin
                    res_idx_next = lo_reg;
                    state_next   = nvbs_pkg::ST_FINISH;
                end
                else
                begin
                    vlo_next   = rd_data_reg;
                    mid_next   = mid_cur;
                    state_next = more_steps ? nvbs_pkg::ST_SEARCH : nvbs_pkg::ST_PICK;
                end
            end
            nvbs_pkg::ST_SEARCH:
            begin
                lo_next  = cur_lo;
                hi_next  = cur_hi;
                mid_next = mid_cur;
                if (rd_gt_x)
                begin
                    vhi_next = rd_data_reg;
                end
                else
                begin
                    vlo_next = rd_data_reg;
                end
                state_next = more_steps ? nvbs_pkg::ST_SEARCH : nvbs_pkg::ST_PICK;
            end
            nvbs_pkg::ST_PICK:
            begin
                // tie goes to the lower index
                res_idx_next = (d_hi < d_lo) ? hi_reg : lo_reg;
                state_next   = nvbs_pkg::ST_FINISH;
            end
            nvbs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    nearest_index_next = res_idx_reg;
                    status_next        = res_status_reg;
                    state_next         = nvbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nvbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nvbs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg            <= lo_next;
        hi_reg            <= hi_next;
        mid_reg           <= mid_next;
        x_reg             <= x_next;
        vlo_reg           <= vlo_next;
        vhi_reg           <= vhi_next;
        res_idx_reg       <= res_idx_next;
        res_status_reg    <= res_status_next;
        nearest_index_reg <= nearest_index_next;
        status_reg        <= status_next;
    end

    assign out_valid     = out_valid_reg;
    assign nearest_index = nearest_index_reg;
    assign status        = status_reg;

`ifndef SYNTHESIS
    // a query holds the input side for at least the end check
    a_query_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && action == nvbs_pkg::ACT_QUERY) |=> in_stall)
        else $error("input not stalled after query accept");

    // halving only runs while the bracket is wider than two adjacent entries
    a_search_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nvbs_pkg::ST_SEARCH) |->
        (mid_reg > lo_reg && mid_reg < hi_reg))
        else $error("search midpoint outside bracket");

    // an ok result is always one end of the current bracket
    a_result_in_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nvbs_pkg::ST_FINISH && res_status_reg == nvbs_pkg::STATUS_OK) |->
        (res_idx_reg == lo_reg || res_idx_reg == hi_reg))
        else $error("result index not at a bracket end");
`endif

endmodule

### verif/nearest_value_binary_search_top_tb.sv
// Self-checking testbench for the nearest value binary search block.
`timescale 1ns / 100ps

module nearest_value_binary_search_top_tb;

    localparam int     IDX_W          = nvbs_pkg::IDX_W;
    localparam int     VAL_W          = nvbs_pkg::VAL_W;
    localparam int     DEPTH          = nvbs_pkg::DEPTH_DEFAULT;
    localparam int     MAX_GAP        = 14;
    localparam int     RANDOM_WORDS   = 200;
    localparam int     WATCHDOG_LIMIT = 3000;
    localparam int     TAIL_CYCLES    = 40;
    localparam int     DRAIN_PAD      = 16;
    localparam int     PRINT_CAP      = 50;
    localparam longint VAL_MAX        = 64'sd2147483647;
    localparam longint VAL_MIN        = -64'sd2147483648;

    // how the table contents of one random block are laid out
    typedef enum int {
        PROF_STRIDE,    // ascending, random step sizes
        PROF_FLAT,      // ascending with runs of duplicates
        PROF_WIDE,      // ascending from the bottom, huge steps, saturates at the top
        PROF_SHUFFLED   // no order at all
    } block_profile_t;

    // where a query target is placed relative to the table
    typedef enum int {
        TGT_RANDOM,     // any 32-bit value
        TGT_EXACT,      // hits a stored value
        TGT_NEAR,       // one off a stored value
        TGT_TIE,        // midpoint of two neighbors, ties when the gap is even
        TGT_TIE_UP,     // one above that midpoint
        TGT_EXTREME,    // most negative or most positive value
        TGT_INSIDE      // somewhere between the two end values
    } target_kind_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             status;
    } nearest_result_t;

    // ------------------------------------------------------------------
    // clock, reset and block ports; every input is known from time zero
    // ------------------------------------------------------------------
    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    in_valid     = 1'b0;
    logic                    in_stall;
    logic                    action       = nvbs_pkg::ACT_WRITE;
    logic        [IDX_W-1:0] entry_index  = '0;
    logic signed [VAL_W-1:0] entry_value  = '0;
    logic        [IDX_W-1:0] lo_index     = '0;
    logic        [IDX_W-1:0] hi_index     = '0;
    logic signed [VAL_W-1:0] target_value = '0;
    logic                    out_valid;
    logic                    out_stall    = 1'b0;
    logic        [IDX_W-1:0] nearest_index;
    logic                    status;

    // shadow of the value table, kept in step with accepted write words
    logic signed [VAL_W-1:0] table_shadow [0:DEPTH-1];

    // expected results in query order
    nearest_result_t expected_nearest[$];

    // run statistics
    int error_count      = 0;
    int write_words      = 0;
    int query_words      = 0;
    int reversed_queries = 0;
    int results_checked  = 0;

    // idle modes, flipped per phase so some stretches run back to back
    bit tx_no_gap   = 1'b0;
    bit rx_no_stall = 1'b0;

    nearest_value_binary_search_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .entry_index   (entry_index),
        .entry_value   (entry_value),
        .lo_index      (lo_index),
        .hi_index      (hi_index),
        .target_value  (target_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .nearest_index (nearest_index),
        .status        (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // End checks first (high end wins), then halve until two neighbors are
    // left and take the nearer one; equal distance goes to the lower index.
    // Differences are taken at 64 bits so the full 33-bit span is exact.
    function automatic logic [IDX_W-1:0] search_nearest(input int lo_i, input int hi_i,
                                                        input longint x);
        int               lo;
        int               hi;
        int               mid;
        longint           gap_hi;
        longint           gap_lo;
        logic [IDX_W-1:0] pick;
        lo = lo_i;
        hi = hi_i;
        if (x >= longint'(table_shadow[hi]))
        begin
            pick = hi[IDX_W-1:0];
            return pick;
        end
        if (x <= longint'(table_shadow[lo]))
        begin
            pick = lo[IDX_W-1:0];
            return pick;
        end
        while (hi > lo + 1)
        begin
            mid = (lo + hi) / 2;
            if (longint'(table_shadow[mid]) > x)
                hi = mid;
            else
                lo = mid;
        end
        gap_hi = longint'(table_shadow[hi]) - x;
        gap_lo = x - longint'(table_shadow[lo]);
        pick   = (gap_hi < gap_lo) ? hi[IDX_W-1:0] : lo[IDX_W-1:0];
        return pick;
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_to_word(input longint v);
        if (v > VAL_MAX)
            v = VAL_MAX;
        if (v < VAL_MIN)
            v = VAL_MIN;
        return v[VAL_W-1:0];
    endfunction

    // target value aimed at the interesting spots of table range [lo, hi]
    function automatic logic signed [VAL_W-1:0] pick_target(input int lo, input int hi);
        target_kind_t kind;
        int           pos;
        longint       t;
        longint       span;
        kind = target_kind_t'($urandom_range(0, 6));
        pos  = $urandom_range(lo, hi);
        case (kind)
            TGT_RANDOM:  t = longint'($signed($urandom));
            TGT_EXACT:   t = table_shadow[pos];
            TGT_NEAR:    t = longint'(table_shadow[pos]) + ($urandom_range(0, 1) ? 1 : -1);
            TGT_TIE,
            TGT_TIE_UP:
            begin
                if (pos < hi)
                    t = ((longint'(table_shadow[pos]) + longint'(table_shadow[pos + 1])) >>> 1)
                        + ((kind == TGT_TIE_UP) ? 1 : 0);
                else
                    t = table_shadow[pos];
            end
            TGT_EXTREME: t = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            default:
            begin
                span = longint'(table_shadow[hi]) - longint'(table_shadow[lo]);
                t    = table_shadow[lo];
                if (span > 0)
                    t = t + longint'($urandom) % (span + 1);
            end
        endcase
        return clamp_to_word(t);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (error_count < PRINT_CAP)
            $display("ERROR @%0t: %s", $time, what);
        error_count++;
    endtask

    // Result side: compare each accepted word with the oldest expectation,
    // then draw a fresh stall stretch for the next one.
    int stall_left = 0;

    always @(posedge clk)
    begin
        nearest_result_t exp_word;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_nearest.size() == 0)
                begin
                    report_mismatch($sformatf("result word index %0d status %0d with no query pending",
                                              nearest_index, status));
                end
                else
                begin
                    exp_word = expected_nearest.pop_front();
                    if (nearest_index !== exp_word.index)
                        report_mismatch($sformatf("nearest_index %0d, expected %0d",
                                                  nearest_index, exp_word.index));
                    if (status !== exp_word.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, exp_word.status));
                    results_checked++;
                end
                stall_left = rx_no_stall ? 0 : $urandom_range(0, MAX_GAP);
            end
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: any cycle that moves a word on either channel resets it
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                         idle_cycles, expected_nearest.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // Send one word. Called at a rising edge; returns at the edge that took
    // the word. With no gap, valid simply stays high for the next word.
    task automatic send_word(input logic act, input int e_idx, input logic signed [VAL_W-1:0] e_val,
                             input int lo, input int hi, input logic signed [VAL_W-1:0] tgt);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        entry_index  <= e_idx[IDX_W-1:0];
        entry_value  <= e_val;
        lo_index     <= lo[IDX_W-1:0];
        hi_index     <= hi[IDX_W-1:0];
        target_value <= tgt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge: update the shadow or predict the result
        if (act == nvbs_pkg::ACT_WRITE)
        begin
            table_shadow[e_idx] = e_val;
            write_words++;
        end
        else
        begin
            query_words++;
            if (hi < lo)
            begin
                reversed_queries++;
                expected_nearest.push_back('{index: lo[IDX_W-1:0],
                                             status: nvbs_pkg::STATUS_REVERSED});
            end
            else
            begin
                expected_nearest.push_back('{index: search_nearest(lo, hi, longint'(tgt)),
                                             status: nvbs_pkg::STATUS_OK});
            end
        end
    endtask

    // query fields ride along with random content on a write, and vice versa
    task automatic write_entry(input int idx, input logic signed [VAL_W-1:0] val);
        send_word(nvbs_pkg::ACT_WRITE, idx, val, $urandom_range(0, DEPTH - 1),
                  $urandom_range(0, DEPTH - 1), $urandom);
    endtask

    task automatic run_query(input int lo, input int hi, input logic signed [VAL_W-1:0] tgt);
        send_word(nvbs_pkg::ACT_QUERY, $urandom_range(0, DEPTH - 1), $urandom, lo, hi, tgt);
    endtask

    // hold off the sender until every query has been answered
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_nearest.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // Small hand-built table: extreme values at both ends of the value range,
    // a duplicate pair at the top indexes, then end hits, ties, a tie across a
    // wide value gap, single-entry and reversed ranges.
    task automatic test_directed_cases();
        tx_no_gap   = 1'b0;
        rx_no_stall = 1'b0;
        write_entry(0, 32'sh8000_0000);
        write_entry(1, -32'sd1000);
        write_entry(2, -32'sd10);
        write_entry(3, 32'sd0);
        write_entry(4, 32'sd10);
        write_entry(5, 32'sd1000);
        write_entry(6, 32'sh7FFF_FFFE);
        write_entry(7, 32'sh7FFF_FFFF);
        write_entry(DEPTH - 2, 32'sd100);
        write_entry(DEPTH - 1, 32'sd100);
        run_query(0, 7, 32'sh8000_0000);      // at the low end value
        run_query(0, 7, 32'sh7FFF_FFFF);      // at the high end value
        run_query(0, 6, 32'sh7FFF_FFFF);      // beyond the high end
        run_query(1, 7, 32'sh8000_0000);      // beyond the low end
        run_query(0, 7, 32'sd0);              // exact hit inside
        run_query(3, 4, 32'sd5);              // tie between neighbors
        run_query(3, 4, 32'sd6);              // just past the tie
        run_query(0, 7, -32'sd505);           // tie found by the search
        run_query(0, 1, -32'sd1073742324);    // tie across a near half-scale gap
        run_query(6, 7, 32'sh7FFF_FFFE);      // top two, at the lower one
        run_query(5, 5, -32'sd7);             // single-entry range
        run_query(6, 2, 32'sd0);              // reversed range
        run_query(DEPTH - 1, 0, 32'sd0);      // reversed, widest spread
        run_query(DEPTH - 2, DEPTH - 1, 32'sd100); // duplicate values at the top
    endtask

    // Whole table ascending across the full value range, so most queries search
    // nearly the whole table and every index bit is written.
    task automatic test_full_range_search();
        int lo;
        int hi;
        tx_no_gap   = 1'b0;
        rx_no_stall = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            write_entry(i, clamp_to_word(VAL_MIN + longint'(i) * 64'sd4194304
                                         + longint'($urandom_range(0, 4194303))));
        repeat (60)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                lo = $urandom_range(0, DEPTH - 1);
                hi = $urandom_range(0, DEPTH - 1);
            end
            else
            begin
                lo = $urandom_range(0, 15);
                hi = $urandom_range(DEPTH - 16, DEPTH - 1);
            end
            run_query(lo, hi, pick_target((lo < hi) ? lo : hi, (lo < hi) ? hi : lo));
        end
    endtask

    task automatic load_block(input int base_idx, input int size, input block_profile_t profile);
        longint cur;
        cur = ($urandom_range(0, 3) == 0) ? VAL_MIN : longint'($signed($urandom));
        if (profile == PROF_WIDE)
            cur = VAL_MIN + longint'($urandom_range(0, 1000));
        for (int i = 0; i < size; i++)
        begin
            if (profile == PROF_SHUFFLED)
                write_entry(base_idx + i, $urandom);
            else
                write_entry(base_idx + i, clamp_to_word(cur));
            case (profile)
                PROF_STRIDE: cur += longint'($urandom_range(1, 1 << $urandom_range(0, 20)));
                PROF_FLAT:   cur += longint'($urandom_range(0, 1));
                PROF_WIDE:   cur += longint'($urandom_range(0, 32'h0FFF_FFFF));
                default:     ;
            endcase
        end
    endtask

    // Random sessions: load a contiguous block (mostly small), then query
    // only inside it so no search ever touches an unwritten entry. A few
    // overwrites inside the block break its order on purpose.
    task automatic test_random_blocks();
        int sent;
        int session;
        int size;
        int base_idx;
        int nq;
        int lo;
        int hi;
        int tmp;
        int choice;
        sent    = 0;
        session = 0;
        while (sent < RANDOM_WORDS)
        begin
            tx_no_gap   = ($urandom_range(0, 3) == 0);
            rx_no_stall = ($urandom_range(0, 3) == 0);
            choice      = $urandom_range(0, 9);
            if (choice == 0)
                size = $urandom_range(41, 300);
            else if (choice == 1)
                size = 1;
            else
                size = $urandom_range(2, 40);
            base_idx = $urandom_range(0, DEPTH - size);
            load_block(base_idx, size, block_profile_t'($urandom_range(0, 3)));
            sent += size;
            nq = $urandom_range(2, (size < 19) ? 2 * size + 2 : 40);
            repeat (nq)
            begin
                choice = $urandom_range(0, 19);
                lo     = $urandom_range(base_idx, base_idx + size - 1);
                hi     = $urandom_range(base_idx, base_idx + size - 1);
                if (choice == 0)
                begin
                    write_entry(lo, $urandom);
                end
                else
                begin
                    if (choice == 1)
                    begin
                        lo = base_idx;
                        hi = base_idx + size - 1;
                    end
                    else if (choice == 2)
                    begin
                        hi = lo;
                    end
                    else if ((choice <= 4) == (lo < hi))
                    begin
                        // reversed for the few, ordered for the rest
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                    run_query(lo, hi, pick_target((lo < hi) ? lo : hi, (lo < hi) ? hi : lo));
                end
                sent++;
            end
            session++;
            if (session % 6 == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        drain_results();
        test_full_range_search();
        drain_results();
        test_random_blocks();

        in_valid <= 1'b0;
        while (expected_nearest.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_nearest.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_nearest.size()));
        $display("Run covered %0d table writes and %0d queries (%0d with reversed range),",
                 write_words, query_words, reversed_queries);
        $display("checked %0d result words: sorted, flat, saturated and unordered tables.",
                 results_checked);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
